@@ rtl/wildcard_byte_pattern_search_assert.svh @@
// Assertion macros for the wildcard byte pattern search block.
// Each use expects clk and arst_n in scope.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH

// Same-cycle implication
`define WBPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wbps: same-cycle check failed");

// Next-cycle implication
`define WBPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wbps: next-cycle check failed");

`endif

@@ rtl/wbps_pkg.sv @@
`default_nettype none

package wbps_pkg;

	localparam int PATTERN_BYTES = 16;
	localparam int CFG_DW        = 64;
	localparam int ADDR_W        = 6;
	localparam int LEN_W         = 5;
	localparam int OFFSET_W      = 32;
	localparam int POS_OUT_W     = 32;

	// Register index, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_PATTERN_LEN  = 3'd2,
		REG_WC_BYTE      = 3'd3,
		REG_WC_ENABLE    = 3'd4,
		REG_START_OFFSET = 3'd5
	} reg_idx_t;

	// Search settings as seen by the datapath (length already clamped)
	typedef struct packed {
		logic [8*PATTERN_BYTES-1:0] pattern;
		logic [LEN_W-1:0]           length;
		logic [7:0]                 wc_byte;
		logic                       wc_en;
		logic [OFFSET_W-1:0]        start_offset;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/wbps_cfg.sv @@
`default_nettype none

module wbps_cfg
	import wbps_pkg::*;
#(
	parameter int PATTERN_MAX = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [63:0]         pattern_low_q;
	logic [63:0]         pattern_high_q;
	logic [LEN_W-1:0]    length_q;
	logic [7:0]          wc_byte_q;
	logic                wc_en_q;
	logic [OFFSET_W-1:0] start_offset_q;
	reg_idx_t            idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;

	// Register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			length_q       <= LEN_W'(1);
			wc_byte_q      <= '0;
			wc_en_q        <= 1'b0;
			start_offset_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PATTERN_LOW:  pattern_low_q  <= pwdata[63:0];
				REG_PATTERN_HIGH: pattern_high_q <= pwdata[63:0];
				REG_PATTERN_LEN:  length_q       <= pwdata[LEN_W-1:0];
				REG_WC_BYTE:      wc_byte_q      <= pwdata[7:0];
				REG_WC_ENABLE:    wc_en_q        <= pwdata[0];
				REG_START_OFFSET: start_offset_q <= pwdata[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PATTERN_LOW:  prdata = pattern_low_q;
			REG_PATTERN_HIGH: prdata = pattern_high_q;
			REG_PATTERN_LEN:  prdata = CFG_DW'(length_q);
			REG_WC_BYTE:      prdata = CFG_DW'(wc_byte_q);
			REG_WC_ENABLE:    prdata = CFG_DW'(wc_en_q);
			REG_START_OFFSET: prdata = CFG_DW'(start_offset_q);
			default:          prdata = '0;
		endcase
	end

	// Clamp length into 1..PATTERN_MAX and pack settings
	always_comb begin
		cfg.pattern      = {pattern_high_q, pattern_low_q};
		cfg.wc_byte      = wc_byte_q;
		cfg.wc_en        = wc_en_q;
		cfg.start_offset = start_offset_q;
		if (length_q == '0)
			cfg.length = LEN_W'(1);
		else if (length_q > LEN_W'(PATTERN_MAX))
			cfg.length = LEN_W'(PATTERN_MAX);
		else
			cfg.length = length_q;
	end

endmodule

`default_nettype wire

@@ rtl/wbps_match.sv @@
`default_nettype none

module wbps_match
	import wbps_pkg::*;
#(
	parameter int PATTERN_MAX   = 16,
	parameter int POSITION_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     advance,
	input  wire logic                     valid_s1,
	input  wire logic [7:0]               data_s1,
	input  wire logic                     last_s1,
	input  wire cfg_t                     cfg,
	output logic                          res_valid_s2,
	output logic                          found_s2,
	output logic      [POSITION_BITS-1:0] first_s2
);

	`include "wildcard_byte_pattern_search_assert.svh"

	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int WIN   = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	logic [7:0]               window_q [WIN];
	logic [POSITION_BITS-1:0] bytes_seen_q;
	logic                     match_reported_q;

	logic [7:0]               rec [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]   byte_ok;
	logic [LEN_W-1:0]         len_m1;
	logic [POSITION_BITS-1:0] first;
	logic                     enough;
	logic                     new_match;
	logic                     take;

	// Window as it stands with the current byte shifted in
	always_comb begin
		rec[0] = data_s1;
		for (int i = 1; i < PATTERN_MAX; i++)
			rec[i] = window_q[i-1];
	end

	// Compare pattern byte k against the byte len-1-k places back
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
		logic [LEN_W-1:0] sel;
		logic [7:0]       pat;
		logic [7:0]       dat;

		assign sel        = cfg.length - LEN_W'(k + 1);
		assign pat        = cfg.pattern[8*k +: 8];
		assign dat        = rec[sel[IDX_W-1:0]];
		assign byte_ok[k] = (LEN_W'(k) >= cfg.length)
			|| (cfg.wc_en && (pat == cfg.wc_byte))
			|| (pat == dat);
	end

	assign len_m1    = cfg.length - LEN_W'(1);
	assign enough    = bytes_seen_q >= POSITION_BITS'(len_m1);
	assign first     = bytes_seen_q - POSITION_BITS'(len_m1);
	assign new_match = !match_reported_q && enough && (&byte_ok);
	assign take      = advance && valid_s1;

	// Stream state: window, byte count, reported flag; restart after last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++)
				window_q[i] <= '0;
			bytes_seen_q     <= '0;
			match_reported_q <= 1'b0;
		end else if (take) begin
			if (last_s1) begin
				for (int i = 0; i < WIN; i++)
					window_q[i] <= '0;
				bytes_seen_q     <= '0;
				match_reported_q <= 1'b0;
			end else begin
				window_q[0] <= data_s1;
				for (int i = 1; i < WIN; i++)
					window_q[i] <= window_q[i-1];
				if (bytes_seen_q != POS_MAX)
					bytes_seen_q <= bytes_seen_q + POSITION_BITS'(1);
				if (new_match)
					match_reported_q <= 1'b1;
			end
		end
	end

	// Result stage: first match, or a miss report on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= valid_s1 && !match_reported_q && (new_match || last_s1);
		end
	end

	// Hold result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			found_s2 <= new_match;
			first_s2 <= first;
		end
	end

	`WBPS_ASSERT_NEXT(a_last_restarts, take && last_s1,
		(bytes_seen_q == '0) && !match_reported_q)
	`WBPS_ASSERT_NEXT(a_match_marks_reported, take && !last_s1 && new_match,
		match_reported_q)
	`WBPS_ASSERT_NEXT(a_reported_sticks, match_reported_q && !(take && last_s1),
		match_reported_q)

endmodule

`default_nettype wire

@@ rtl/wbps_out.sv @@
`default_nettype none

module wbps_out
	import wbps_pkg::*;
#(
	parameter int POSITION_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     advance,
	input  wire logic                     res_valid_s2,
	input  wire logic                     found_s2,
	input  wire logic [POSITION_BITS-1:0] first_s2,
	input  wire logic [OFFSET_W-1:0]      start_offset,
	output logic                          out_valid,
	output logic                          found,
	output logic      [POS_OUT_W-1:0]     match_position
);

	localparam int SUM_W = ((POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W) + 1;
	localparam logic [SUM_W-1:0] SUM_MAX =
		{{(SUM_W - POSITION_BITS){1'b0}}, {POSITION_BITS{1'b1}}};

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sat;
	logic             out_valid_q;
	logic             found_q;
	logic [POS_OUT_W-1:0] position_q;

	// Add start offset, saturate at the position range
	assign sum = SUM_W'(start_offset) + SUM_W'(first_s2);
	assign sat = (sum > SUM_MAX) ? SUM_MAX : sum;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= res_valid_s2;
	end

	// Output register payload; a miss reports position zero
	always_ff @(posedge clk) begin
		if (advance) begin
			found_q    <= found_s2;
			position_q <= found_s2 ? sat[POS_OUT_W-1:0] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_position = position_q;

endmodule

`default_nettype wire

@@ rtl/wildcard_byte_pattern_search.sv @@
`default_nettype none

// Wildcard byte pattern search: scans a byte stream (s_tdata, s_tlast marks the last byte)
// for the first occurrence of a programmed pattern of 1..PATTERN_MAX bytes, where a pattern
// byte equal to the wildcard byte matches anything while wildcards are enabled. Each stream
// gives exactly one result: on the first match, m_tuser[0]=1 and m_tdata holds start_offset
// plus the index of the match's first byte (saturated at 2**POSITION_BITS-1); if the stream
// ends without a match, m_tuser[0]=0 and m_tdata=0 on its last byte. The block takes one
// byte per clock while s_tready is high; a byte runs through an input register, the compare
// register and the output register before m_tvalid for its result rises. s_tready drops
// only while the output register holds a result that m_tready has not taken. Program the
// registers over APB only while no stream is in flight.
module wildcard_byte_pattern_search
	import wbps_pkg::*;
#(
	parameter int PATTERN_MAX   = 16,
	parameter int POSITION_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// APB configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready,
	// Byte stream in
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] data_byte
	input  wire logic              s_tlast,   // last_byte
	// Result out
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [31:0]       m_tdata,   // [31:0] match_position
	output logic      [0:0]        m_tuser    // [0] found
);

	cfg_t                     cfg;
	logic                     advance;
	logic                     valid_s1;
	logic [7:0]               data_s1;
	logic                     last_s1;
	logic                     res_valid_s2;
	logic                     found_s2;
	logic [POSITION_BITS-1:0] first_s2;
	logic                     found;

	// Whole pipeline moves unless an untaken result sits in the output register
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	wbps_cfg #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= s_tvalid;
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	wbps_match #(
		.PATTERN_MAX   (PATTERN_MAX),
		.POSITION_BITS (POSITION_BITS)
	) u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.valid_s1     (valid_s1),
		.data_s1      (data_s1),
		.last_s1      (last_s1),
		.cfg          (cfg),
		.res_valid_s2 (res_valid_s2),
		.found_s2     (found_s2),
		.first_s2     (first_s2)
	);

	wbps_out #(
		.POSITION_BITS (POSITION_BITS)
	) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.res_valid_s2   (res_valid_s2),
		.found_s2       (found_s2),
		.first_s2       (first_s2),
		.start_offset   (cfg.start_offset),
		.out_valid      (m_tvalid),
		.found          (found),
		.match_position (m_tdata)
	);

	assign m_tuser = found;

endmodule

`default_nettype wire
